// ----- hw/rtl/gf2dp_pkg.sv -----
// gf2dp_pkg: types, constants and carry-less helper functions for the
// gf2(2^192) dot-product accumulator; no dependencies
package gf2dp_pkg;

	localparam int WORD_W  = 64;
	localparam int ELEM_W  = 192;
	localparam int PROD_W  = 384;
	localparam int CHUNK_W = 32;
	localparam int CHUNKS  = ELEM_W / CHUNK_W;
	localparam int PARTS   = CHUNKS * CHUNKS;
	localparam int PART_W  = 2 * CHUNK_W - 1;
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = 1;
	localparam int QCNT_W  = 2;

	typedef logic [PART_W-1:0] part_t;
	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [ELEM_W-1:0] elem_t;

	typedef struct packed {
		elem_t left;
		elem_t right;
		logic  last;
	} item_t;

	// 32 x 32 carry-less product
	function automatic part_t clmul32(input logic [CHUNK_W-1:0] a,
			input logic [CHUNK_W-1:0] b);
		part_t r;
		r = '0;
		for (int i = 0; i < CHUNK_W; i++) begin
			if (b[i]) begin
				r = r ^ (part_t'(a) << i);
			end
		end
		return r;
	endfunction

	// x * (x^7 + x^2 + x + 1), high word over low word
	function automatic logic [2*WORD_W-1:0] times_tail(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] hi;
		lo = x ^ (x << 1) ^ (x << 2) ^ (x << 7);
		hi = (x >> 63) ^ (x >> 62) ^ (x >> 57);
		return {hi, lo};
	endfunction

	// fold words 5, 4, 3 down modulo x^192 + x^7 + x^2 + x + 1
	function automatic elem_t reduce(input prod_t acc);
		logic [5:0][WORD_W-1:0] w;
		logic [2*WORD_W-1:0]    t;
		w = acc;
		t = times_tail(w[5]);
		w[2] = w[2] ^ t[WORD_W-1:0];
		w[3] = w[3] ^ t[2*WORD_W-1:WORD_W];
		t = times_tail(w[4]);
		w[1] = w[1] ^ t[WORD_W-1:0];
		w[2] = w[2] ^ t[2*WORD_W-1:WORD_W];
		t = times_tail(w[3]);
		w[0] = w[0] ^ t[WORD_W-1:0];
		w[1] = w[1] ^ t[2*WORD_W-1:WORD_W];
		return {w[2], w[1], w[0]};
	endfunction

endpackage

// ----- hw/rtl/gf2dp_front.sv -----
// gf2dp_front: input register that takes one operand pair per cycle unless
// item_stall is high, and pushes it into the work queue; uses gf2dp_pkg
module gf2dp_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [gf2dp_pkg::WORD_W-1:0] left_low,
	input  logic [gf2dp_pkg::WORD_W-1:0] left_mid,
	input  logic [gf2dp_pkg::WORD_W-1:0] left_high,
	input  logic [gf2dp_pkg::WORD_W-1:0] right_low,
	input  logic [gf2dp_pkg::WORD_W-1:0] right_mid,
	input  logic [gf2dp_pkg::WORD_W-1:0] right_high,
	input  logic                         final_pair,
	input  logic                         q_full,
	output logic                         q_push,
	output gf2dp_pkg::item_t             q_item
);
	import gf2dp_pkg::*;

	logic  hold_valid_q;
	item_t hold_q;
	logic  take;

	assign item_stall = hold_valid_q && q_full;
	assign take       = item_valid && !item_stall;
	assign q_push     = hold_valid_q && !q_full;
	assign q_item     = hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (take) begin
			hold_valid_q <= 1'b1;
		end else if (q_push) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hold_q.left  <= {left_high, left_mid, left_low};
			hold_q.right <= {right_high, right_mid, right_low};
			hold_q.last  <= final_pair;
		end
	end

endmodule

// ----- hw/rtl/gf2dp_queue.sv -----
// gf2dp_queue: two-entry operand-pair queue between front and back
// uses gf2dp_pkg
module gf2dp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  gf2dp_pkg::item_t push_item,
	output logic             full,
	input  logic             pop,
	output gf2dp_pkg::item_t pop_item,
	output logic             empty
);
	import gf2dp_pkg::*;

	item_t             mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = count_q == QCNT_W'(QDEPTH);
	assign empty    = count_q == '0;
	assign pop_item = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- hw/rtl/gf2dp_back.sv -----
// gf2dp_back: partial-product, product and accumulate/reduce (result) stages
// uses gf2dp_pkg
module gf2dp_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         empty,
	input  gf2dp_pkg::item_t             pop_item,
	output logic                         pop,
	output logic                         sum_valid,
	input  logic                         sum_stall,
	output logic [gf2dp_pkg::WORD_W-1:0] sum_low,
	output logic [gf2dp_pkg::WORD_W-1:0] sum_mid,
	output logic [gf2dp_pkg::WORD_W-1:0] sum_high
);
	import gf2dp_pkg::*;

	part_t part_d  [PARTS];
	part_t part_s1 [PARTS];
	logic  v_s1;
	logic  last_s1;
	prod_t prod_d;
	prod_t prod_s2;
	logic  v_s2;
	logic  last_s2;
	prod_t acc_q;
	prod_t acc_next;
	elem_t sum_q;
	logic  sum_valid_q;
	logic  adv;

	assign adv = !(sum_valid_q && sum_stall);
	assign pop = adv && !empty;

	always_comb begin
		for (int i = 0; i < CHUNKS; i++) begin
			for (int j = 0; j < CHUNKS; j++) begin
				part_d[i*CHUNKS+j] = clmul32(pop_item.left[i*CHUNK_W +: CHUNK_W],
					pop_item.right[j*CHUNK_W +: CHUNK_W]);
			end
		end
	end

	always_comb begin
		prod_d = '0;
		for (int i = 0; i < CHUNKS; i++) begin
			for (int j = 0; j < CHUNKS; j++) begin
				prod_d[(i+j)*CHUNK_W +: PART_W] = prod_d[(i+j)*CHUNK_W +: PART_W]
					^ part_s1[i*CHUNKS+j];
			end
		end
	end

	assign acc_next = acc_q ^ prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			sum_valid_q <= 1'b0;
			acc_q       <= '0;
		end else if (adv) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			if (v_s2) begin
				if (last_s2) begin
					acc_q       <= '0;
					sum_valid_q <= 1'b1;
				end else begin
					acc_q       <= acc_next;
					sum_valid_q <= 1'b0;
				end
			end else begin
				sum_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			part_s1 <= part_d;
			last_s1 <= pop_item.last;
		end
		if (adv && v_s1) begin
			prod_s2 <= prod_d;
			last_s2 <= last_s1;
		end
		if (adv && v_s2 && last_s2) begin
			sum_q <= reduce(acc_next);
		end
	end

	assign sum_valid = sum_valid_q;
	assign sum_low   = sum_q[WORD_W-1:0];
	assign sum_mid   = sum_q[2*WORD_W-1:WORD_W];
	assign sum_high  = sum_q[3*WORD_W-1:2*WORD_W];

endmodule

// ----- hw/rtl/gf2_192_dot_product_accumulator.sv -----
// gf2_192_dot_product_accumulator: top level, joins front, queue and back
// uses gf2dp_pkg, gf2dp_front, gf2dp_queue, gf2dp_back
//
// Takes one operand pair per cycle unless item_stall is high and XORs its
// 383-bit carry-less product into an unreduced accumulator; a pair with
// final_pair set closes the run, and the reduced 192-bit sum comes out as
// three 64-bit words once that pair has passed the input register, queue,
// 32 x 32 partial-product stage, product stage and accumulate and reduce
// stage. The back end moves every stage each cycle unless the result register
// is held by sum_stall; the two-entry queue absorbs the front then.
module gf2_192_dot_product_accumulator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [gf2dp_pkg::WORD_W-1:0] left_low,
	input  logic [gf2dp_pkg::WORD_W-1:0] left_mid,
	input  logic [gf2dp_pkg::WORD_W-1:0] left_high,
	input  logic [gf2dp_pkg::WORD_W-1:0] right_low,
	input  logic [gf2dp_pkg::WORD_W-1:0] right_mid,
	input  logic [gf2dp_pkg::WORD_W-1:0] right_high,
	input  logic                         final_pair,
	output logic                         sum_valid,
	input  logic                         sum_stall,
	output logic [gf2dp_pkg::WORD_W-1:0] sum_low,
	output logic [gf2dp_pkg::WORD_W-1:0] sum_mid,
	output logic [gf2dp_pkg::WORD_W-1:0] sum_high
);
	import gf2dp_pkg::*;

	logic  q_full;
	logic  q_push;
	item_t q_item;
	logic  q_pop;
	logic  q_empty;
	item_t q_head;

	gf2dp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.left_low   (left_low),
		.left_mid   (left_mid),
		.left_high  (left_high),
		.right_low  (right_low),
		.right_mid  (right_mid),
		.right_high (right_high),
		.final_pair (final_pair),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (q_item)
	);

	gf2dp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (q_head),
		.empty     (q_empty)
	);

	gf2dp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.pop_item  (q_head),
		.pop       (q_pop),
		.sum_valid (sum_valid),
		.sum_stall (sum_stall),
		.sum_low   (sum_low),
		.sum_mid   (sum_mid),
		.sum_high  (sum_high)
	);

endmodule
